// File: design/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared constants and types of the keypad code lock unit.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KCL_MAX_DIGITS = 6;

    // command codes
    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_UNLOCK = 2'd1;
    localparam logic [1:0] CMD_CHANGE = 2'd2;

    // key codes
    localparam logic [3:0] KEY_HASH = 4'd10;
    localparam logic [3:0] KEY_STAR = 4'd11;

    // session modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_UNLOCK = 2'd1;
    localparam logic [1:0] MODE_CHANGE = 2'd2;

    // event codes
    localparam logic [3:0] EV_DIGIT    = 4'd0;
    localparam logic [3:0] EV_IGNORED  = 4'd1;
    localparam logic [3:0] EV_UNLOCK   = 4'd2;
    localparam logic [3:0] EV_WRONG    = 4'd3;
    localparam logic [3:0] EV_SHORT    = 4'd4;
    localparam logic [3:0] EV_FIRST    = 4'd5;
    localparam logic [3:0] EV_SAVED    = 4'd6;
    localparam logic [3:0] EV_MISMATCH = 4'd7;
    localparam logic [3:0] EV_RESTART  = 4'd8;
    localparam logic [3:0] EV_CANCEL   = 4'd9;
    localparam logic [3:0] EV_STARTED  = 4'd10;

    // code after reset: digits 1 2 3 4 5 6, first digit in the lowest nibble
    localparam logic [23:0] RESET_CODE       = 24'h654321;
    localparam int          RESET_CODE_COUNT = 6;
    localparam logic [2:0]  MIN_LEN_RESET    = 3'd4;

    typedef struct packed {
        logic [3:0] event_res;
        logic [2:0] entered_length;
        logic [1:0] mode_now;
        logic       confirm_step;
    } kcl_result_t;

endpackage

// File: design/kcl_if.sv
// ----------------------------------------------------------------------------
// kcl_in_if / kcl_out_if
// Valid/ready channels for key events and lock results.
// ----------------------------------------------------------------------------
interface kcl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] key_code;

    modport source (output valid, output command, output key_code, input ready);
    modport sink   (input valid, input command, input key_code, output ready);
endinterface

interface kcl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [2:0] entered_length;
    logic [1:0] mode_now;
    logic       confirm_step;

    modport source (output valid, output event_res, output entered_length,
                    output mode_now, output confirm_step, input ready);
    modport sink   (input valid, input event_res, input entered_length,
                    input mode_now, input confirm_step, output ready);
endinterface

// File: design/kcl_step.sv
// ----------------------------------------------------------------------------
// kcl_step
// Next-state and result logic for one key event.
// ----------------------------------------------------------------------------
module kcl_step
    import kcl_pkg::*;
#(
    parameter int MAX_DIGITS = KCL_MAX_DIGITS,
    parameter int CNT_W      = 3,
    parameter int CODE_W     = 24
)
(
    input  logic [1:0]        command,
    input  logic [3:0]        key_code,
    input  logic [2:0]        min_len,
    input  logic [1:0]        mode,
    input  logic              confirm,
    input  logic [CODE_W-1:0] entry_digits,
    input  logic [CNT_W-1:0]  entry_count,
    input  logic [CODE_W-1:0] first_digits,
    input  logic [CNT_W-1:0]  first_count,
    input  logic [CODE_W-1:0] stored_code,
    input  logic [CNT_W-1:0]  stored_count,
    output logic [1:0]        mode_next,
    output logic              confirm_next,
    output logic [CODE_W-1:0] entry_digits_next,
    output logic [CNT_W-1:0]  entry_count_next,
    output logic [CODE_W-1:0] first_digits_next,
    output logic [CNT_W-1:0]  first_count_next,
    output logic [CODE_W-1:0] stored_code_next,
    output logic [CNT_W-1:0]  stored_count_next,
    output kcl_result_t       result
);

    logic             unlock_match;
    logic             repeat_match;
    logic [2:0]       need;
    logic [3:0]       ev;
    logic [CODE_W-1:0] appended;

    // per-digit compare, digits at or past the count do not matter
    always_comb
    begin
        unlock_match = (entry_count == stored_count);
        repeat_match = (entry_count == first_count);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (CNT_W'(i) < entry_count)
            begin
                if (entry_digits[4*i +: 4] != stored_code[4*i +: 4])
                    unlock_match = 1'b0;
                if (entry_digits[4*i +: 4] != first_digits[4*i +: 4])
                    repeat_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        appended = entry_digits;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (CNT_W'(i) == entry_count)
                appended[4*i +: 4] = key_code;
        end
    end

    assign need = (min_len == 3'd0) ? 3'd1 : min_len;

    always_comb
    begin
        mode_next         = mode;
        confirm_next      = confirm;
        entry_digits_next = entry_digits;
        entry_count_next  = entry_count;
        first_digits_next = first_digits;
        first_count_next  = first_count;
        stored_code_next  = stored_code;
        stored_count_next = stored_count;
        ev                = EV_IGNORED;

        case (command)
            CMD_UNLOCK, CMD_CHANGE:
            begin
                mode_next         = (command == CMD_UNLOCK) ? MODE_UNLOCK : MODE_CHANGE;
                confirm_next      = 1'b0;
                entry_digits_next = '0;
                entry_count_next  = '0;
                first_digits_next = '0;
                first_count_next  = '0;
                ev                = EV_STARTED;
            end
            CMD_KEY:
            begin
                if (mode != MODE_IDLE)
                begin
                    if (key_code inside {[4'd0:4'd9]})
                    begin
                        if (entry_count < CNT_W'(MAX_DIGITS))
                        begin
                            entry_digits_next = appended;
                            entry_count_next  = entry_count + CNT_W'(1);
                            ev                = EV_DIGIT;
                        end
                    end
                    else if (key_code == KEY_STAR)
                    begin
                        entry_digits_next = '0;
                        entry_count_next  = '0;
                        confirm_next      = 1'b0;
                        if (mode == MODE_CHANGE && confirm)
                        begin
                            ev = EV_RESTART;
                        end
                        else
                        begin
                            mode_next         = MODE_IDLE;
                            first_digits_next = '0;
                            first_count_next  = '0;
                            ev                = EV_CANCEL;
                        end
                    end
                    else if (key_code == KEY_HASH)
                    begin
                        if (mode == MODE_UNLOCK)
                        begin
                            mode_next         = MODE_IDLE;
                            confirm_next      = 1'b0;
                            entry_digits_next = '0;
                            entry_count_next  = '0;
                            first_digits_next = '0;
                            first_count_next  = '0;
                            ev                = unlock_match ? EV_UNLOCK : EV_WRONG;
                        end
                        else if (entry_count < CNT_W'(need))
                        begin
                            ev = EV_SHORT;
                        end
                        else if (!confirm)
                        begin
                            first_digits_next = entry_digits;
                            first_count_next  = entry_count;
                            entry_digits_next = '0;
                            entry_count_next  = '0;
                            confirm_next      = 1'b1;
                            ev                = EV_FIRST;
                        end
                        else
                        begin
                            // buffers hold zeros past their count, so no mask needed
                            if (repeat_match)
                            begin
                                stored_code_next  = first_digits;
                                stored_count_next = first_count;
                                ev                = EV_SAVED;
                            end
                            else
                            begin
                                ev = EV_MISMATCH;
                            end
                            mode_next         = MODE_IDLE;
                            confirm_next      = 1'b0;
                            entry_digits_next = '0;
                            entry_count_next  = '0;
                            first_digits_next = '0;
                            first_count_next  = '0;
                        end
                    end
                end
            end
            default:
            begin
                ev = EV_IGNORED;
            end
        endcase
    end

    assign result.event_res      = ev;
    assign result.entered_length = 3'(entry_count_next);
    assign result.mode_now       = mode_next;
    assign result.confirm_step   = confirm_next;

endmodule

// File: design/keypad_code_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_unit
// Keypad code lock: unlock and change-code sessions over a key event stream.
// ----------------------------------------------------------------------------
// path: input transaction held in the input register, then its result in the result
//   register; throughput: one transaction per cycle while res_out.ready is high (a stalled result stalls both)
// the rate is set by the combinational next-state logic behind the input register
// reset: session idle, buffers cleared, stored code 123456, min length 4
// ----------------------------------------------------------------------------
module keypad_code_lock_unit
    import kcl_pkg::*;
#(
    parameter int MAX_DIGITS = KCL_MAX_DIGITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_data,
    kcl_in_if.sink           key_in,
    kcl_out_if.source        res_out
);

    localparam int CNT_MAX = (MAX_DIGITS > RESET_CODE_COUNT) ? MAX_DIGITS : RESET_CODE_COUNT;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int CODE_W  = 4 * MAX_DIGITS;

    logic [2:0]        min_len_reg;
    logic              in_valid_reg;
    logic [1:0]        command_reg;
    logic [3:0]        key_reg;
    logic              out_valid_reg;
    kcl_result_t       result_reg;

    logic [1:0]        mode_reg,         mode_next;
    logic              confirm_reg,      confirm_next;
    logic [CODE_W-1:0] entry_digits_reg, entry_digits_next;
    logic [CNT_W-1:0]  entry_count_reg,  entry_count_next;
    logic [CODE_W-1:0] first_digits_reg, first_digits_next;
    logic [CNT_W-1:0]  first_count_reg,  first_count_next;
    logic [CODE_W-1:0] stored_code_reg,  stored_code_next;
    logic [CNT_W-1:0]  stored_count_reg, stored_count_next;
    kcl_result_t       result_next;

    logic              advance;

    // input register moves into the result register when that one is free
    assign advance      = in_valid_reg && (!out_valid_reg || res_out.ready);
    assign key_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= MIN_LEN_RESET;
        else if (cfg_we)
            min_len_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (key_in.ready)
        begin
            in_valid_reg <= key_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_in.valid && key_in.ready)
        begin
            command_reg <= key_in.command;
            key_reg     <= key_in.key_code;
        end
    end

    kcl_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W),
        .CODE_W     (CODE_W)
    ) u_step (
        .command           (command_reg),
        .key_code          (key_reg),
        .min_len           (min_len_reg),
        .mode              (mode_reg),
        .confirm           (confirm_reg),
        .entry_digits      (entry_digits_reg),
        .entry_count       (entry_count_reg),
        .first_digits      (first_digits_reg),
        .first_count       (first_count_reg),
        .stored_code       (stored_code_reg),
        .stored_count      (stored_count_reg),
        .mode_next         (mode_next),
        .confirm_next      (confirm_next),
        .entry_digits_next (entry_digits_next),
        .entry_count_next  (entry_count_next),
        .first_digits_next (first_digits_next),
        .first_count_next  (first_count_next),
        .stored_code_next  (stored_code_next),
        .stored_count_next (stored_count_next),
        .result            (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            confirm_reg      <= 1'b0;
            entry_digits_reg <= '0;
            entry_count_reg  <= '0;
            first_digits_reg <= '0;
            first_count_reg  <= '0;
            stored_code_reg  <= CODE_W'(RESET_CODE);
            stored_count_reg <= CNT_W'(RESET_CODE_COUNT);
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            confirm_reg      <= confirm_next;
            entry_digits_reg <= entry_digits_next;
            entry_count_reg  <= entry_count_next;
            first_digits_reg <= first_digits_next;
            first_count_reg  <= first_count_next;
            stored_code_reg  <= stored_code_next;
            stored_count_reg <= stored_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.event_res      = result_reg.event_res;
    assign res_out.entered_length = result_reg.entered_length;
    assign res_out.mode_now       = result_reg.mode_now;
    assign res_out.confirm_step   = result_reg.confirm_step;

`ifndef NO_ASSERTIONS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (entry_count_reg == '0 && !confirm_reg))
        else $error("idle session holds entry digits or confirm flag");

    a_confirm_change: assert property (@(posedge clk) disable iff (!rst_n)
        confirm_reg |-> (mode_reg == MODE_CHANGE))
        else $error("confirm flag set outside change session");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_DIGITS))
        else $error("entry count beyond buffer depth");

    a_stored_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg != '0)
        else $error("empty code stored");

    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after transaction moved out of input register");
`endif

endmodule
